// ===== rtl/csc_pkg.sv =====
// shared types and constants for the clamped cosine similarity core
package csc_pkg;

    localparam int ELEM_BITS   = 16;
    localparam int DEF_MAX_DIM = 256;
    localparam int DOT_W       = 40;
    localparam int NORM_W      = 39;
    localparam int MAG_W       = DOT_W - 1;
    localparam int PROD_W      = 2 * NORM_W;
    localparam int QUOT_W      = 30;
    localparam int ROOT_W      = QUOT_W / 2;
    localparam int SREM_W      = ROOT_W + 2;
    localparam int SIM_W       = 16;
    localparam int STEP_W      = 6;
    localparam int Q_DEPTH     = 2;

    localparam logic [SIM_W-1:0] ONE_Q15 = SIM_W'(32768);

    localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(MAG_W - 1);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(QUOT_W - 1);
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);

    typedef struct packed {
        logic [DOT_W-1:0]  dot;
        logic [NORM_W-1:0] norm_a;
        logic [NORM_W-1:0] norm_b;
        logic              too_long;
    } t_vec_rec;

    typedef struct packed {
        logic     valid;
        t_vec_rec rec;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CMP,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } t_back_state;

endpackage

// ===== rtl/cosine_similarity_clamped_core.sv =====
// top level of the clamped cosine similarity core
//
//  channel   signals                                   direction
//  pairs     i_valid o_stall i_a_elem i_b_elem i_last  in
//  results   o_valid i_stall o_similarity
//            o_degenerate o_length_error               out
//
// the front takes one element pair per cycle while the two-entry queue has room
// the back handles one vector at a time: 39 shift-add multiply steps,
// one compare, 30 division steps, 15 square root steps and load/unload
// zero-norm or non-positive dot product vectors go from idle straight to done
// synchronous active-low reset clears accumulators, queue and back state
// o_stall rises while the queue is full; results wait in the output register
module cosine_similarity_clamped_core #(
    parameter int MAX_DIM = csc_pkg::DEF_MAX_DIM
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [csc_pkg::ELEM_BITS-1:0] i_a_elem,
    input  logic signed [csc_pkg::ELEM_BITS-1:0] i_b_elem,
    input  logic                                 i_last,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [csc_pkg::SIM_W-1:0]            o_similarity,
    output logic                                 o_degenerate,
    output logic                                 o_length_error
);
    import csc_pkg::*;

    t_push    w_push;
    t_q_stat  w_stat;
    t_vec_rec w_rec;
    logic     w_pop;

    assign o_stall = w_stat.full;

    csc_front #(
        .MAX_DIM(MAX_DIM)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_stall  (o_stall),
        .i_a_elem (i_a_elem),
        .i_b_elem (i_b_elem),
        .i_last   (i_last),
        .o_push   (w_push)
    );

    csc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_stat  (w_stat),
        .o_rec   (w_rec)
    );

    csc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rec          (w_rec),
        .i_stat         (w_stat),
        .o_pop          (w_pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_similarity   (o_similarity),
        .o_degenerate   (o_degenerate),
        .o_length_error (o_length_error)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid |-> !w_stat.full)
        else $error("request pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_stat.empty)
        else $error("pop from empty queue");

    a_sim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_similarity <= ONE_Q15)
        else $error("similarity above one");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> o_similarity == '0)
        else $error("degenerate result with nonzero similarity");

endmodule

// ===== rtl/csc_front.sv =====
// front end: accepts element pairs and accumulates dot product and sums of squares
module csc_front #(
    parameter int MAX_DIM = csc_pkg::DEF_MAX_DIM
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                i_stall,
    input  logic signed [csc_pkg::ELEM_BITS-1:0] i_a_elem,
    input  logic signed [csc_pkg::ELEM_BITS-1:0] i_b_elem,
    input  logic                                i_last,
    output csc_pkg::t_push                      o_push
);
    import csc_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIM + 1);

    logic [DOT_W-1:0]  r_dot,      n_dot;
    logic [NORM_W-1:0] r_norm_a,   n_norm_a;
    logic [NORM_W-1:0] r_norm_b,   n_norm_b;
    logic [CNT_W-1:0]  r_cnt,      n_cnt;
    logic              r_too_long, n_too_long;

    logic signed [2*ELEM_BITS-1:0] w_ab;
    logic signed [2*ELEM_BITS-1:0] w_aa;
    logic signed [2*ELEM_BITS-1:0] w_bb;
    logic                          w_accept;
    logic                          w_room;

    assign w_ab     = (2*ELEM_BITS)'(i_a_elem) * (2*ELEM_BITS)'(i_b_elem);
    assign w_aa     = (2*ELEM_BITS)'(i_a_elem) * (2*ELEM_BITS)'(i_a_elem);
    assign w_bb     = (2*ELEM_BITS)'(i_b_elem) * (2*ELEM_BITS)'(i_b_elem);
    assign w_accept = i_valid && !i_stall;
    assign w_room   = r_cnt < CNT_W'(MAX_DIM);

    always_comb begin
        n_dot      = r_dot;
        n_norm_a   = r_norm_a;
        n_norm_b   = r_norm_b;
        n_cnt      = r_cnt;
        n_too_long = r_too_long;
        if (w_room) begin
            n_dot    = r_dot + DOT_W'(w_ab);
            n_norm_a = r_norm_a + NORM_W'($unsigned(w_aa));
            n_norm_b = r_norm_b + NORM_W'($unsigned(w_bb));
            n_cnt    = r_cnt + 1'b1;
        end else begin
            n_too_long = 1'b1;
        end
    end

    always_comb begin
        o_push.valid        = w_accept && i_last;
        o_push.rec.dot      = n_dot;
        o_push.rec.norm_a   = n_norm_a;
        o_push.rec.norm_b   = n_norm_b;
        o_push.rec.too_long = n_too_long;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot      <= '0;
            r_norm_a   <= '0;
            r_norm_b   <= '0;
            r_cnt      <= '0;
            r_too_long <= 1'b0;
        end else if (w_accept) begin
            if (i_last) begin
                r_dot      <= '0;
                r_norm_a   <= '0;
                r_norm_b   <= '0;
                r_cnt      <= '0;
                r_too_long <= 1'b0;
            end else begin
                r_dot      <= n_dot;
                r_norm_a   <= n_norm_a;
                r_norm_b   <= n_norm_b;
                r_cnt      <= n_cnt;
                r_too_long <= n_too_long;
            end
        end
    end

endmodule

// ===== rtl/csc_queue.sv =====
// short queue of finished vector sums between front and back
module csc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  csc_pkg::t_push    i_push,
    input  logic              i_pop,
    output csc_pkg::t_q_stat  o_stat,
    output csc_pkg::t_vec_rec o_rec
);
    import csc_pkg::*;

    localparam int AW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_vec_rec        r_mem [Q_DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;

    assign o_stat.full  = r_cnt == CW'(Q_DEPTH);
    assign o_stat.empty = r_cnt == '0;
    assign o_rec        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= (r_wr == AW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push.valid, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/csc_back.sv =====
// back end: shift-add multiplies, long division and square root per vector, with output register
module csc_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  csc_pkg::t_vec_rec               i_rec,
    input  csc_pkg::t_q_stat                i_stat,
    output logic                            o_pop,
    input  logic                            i_stall,
    output logic                            o_valid,
    output logic [csc_pkg::SIM_W-1:0]       o_similarity,
    output logic                            o_degenerate,
    output logic                            o_length_error
);
    import csc_pkg::*;

    t_back_state          r_state,   n_state;
    logic [STEP_W-1:0]    r_step,    n_step;
    logic [PROD_W-1:0]    r_md,      n_md;
    logic [MAG_W-1:0]     r_qd,      n_qd;
    logic [PROD_W-1:0]    r_pd,      n_pd;
    logic [PROD_W-1:0]    r_mn,      n_mn;
    logic [NORM_W-1:0]    r_qn,      n_qn;
    logic [PROD_W-1:0]    r_pn,      n_pn;
    logic [PROD_W-1:0]    r_rem,     n_rem;
    logic [QUOT_W-1:0]    r_q,       n_q;
    logic [SREM_W-1:0]    r_srem,    n_srem;
    logic [ROOT_W-1:0]    r_root,    n_root;
    logic [SIM_W-1:0]     r_sim,     n_sim;
    logic                 r_degen,   n_degen;
    logic                 r_lerr,    n_lerr;
    logic                 r_out_valid, n_out_valid;
    logic [SIM_W-1:0]     r_out_sim,   n_out_sim;
    logic                 r_out_degen, n_out_degen;
    logic                 r_out_lerr,  n_out_lerr;

    logic [PROD_W:0]      w_rem2;
    logic [PROD_W:0]      w_diff;
    logic                 w_div_ge;
    logic [SREM_W+1:0]    w_rem4;
    logic [SREM_W+1:0]    w_trial;
    logic                 w_sq_ge;
    logic [SREM_W+1:0]    w_sq_diff;

    assign w_rem2    = {r_rem, 1'b0};
    assign w_diff    = w_rem2 - {1'b0, r_pn};
    assign w_div_ge  = w_rem2 >= {1'b0, r_pn};
    assign w_rem4    = {r_srem, r_q[QUOT_W-1 -: 2]};
    assign w_trial   = (SREM_W + 2)'({r_root, 2'b01});
    assign w_sq_ge   = w_rem4 >= w_trial;
    assign w_sq_diff = w_rem4 - w_trial;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_md        = r_md;
        n_qd        = r_qd;
        n_pd        = r_pd;
        n_mn        = r_mn;
        n_qn        = r_qn;
        n_pn        = r_pn;
        n_rem       = r_rem;
        n_q         = r_q;
        n_srem      = r_srem;
        n_root      = r_root;
        n_sim       = r_sim;
        n_degen     = r_degen;
        n_lerr      = r_lerr;
        n_out_valid = r_out_valid && i_stall;
        n_out_sim   = r_out_sim;
        n_out_degen = r_out_degen;
        n_out_lerr  = r_out_lerr;
        o_pop       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (!i_stat.empty) begin
                    o_pop   = 1'b1;
                    n_lerr  = i_rec.too_long;
                    n_sim   = '0;
                    n_degen = 1'b0;
                    n_md    = PROD_W'(i_rec.dot[MAG_W-1:0]);
                    n_qd    = i_rec.dot[MAG_W-1:0];
                    n_mn    = PROD_W'(i_rec.norm_a);
                    n_qn    = i_rec.norm_b;
                    n_pd    = '0;
                    n_pn    = '0;
                    n_step  = '0;
                    if (i_rec.norm_a == '0 || i_rec.norm_b == '0) begin
                        n_degen = 1'b1;
                        n_state = ST_DONE;
                    end else if (i_rec.dot[DOT_W-1] || i_rec.dot == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                if (r_qd[0]) begin
                    n_pd = r_pd + r_md;
                end
                if (r_qn[0]) begin
                    n_pn = r_pn + r_mn;
                end
                n_md   = {r_md[PROD_W-2:0], 1'b0};
                n_mn   = {r_mn[PROD_W-2:0], 1'b0};
                n_qd   = {1'b0, r_qd[MAG_W-1:1]};
                n_qn   = {1'b0, r_qn[NORM_W-1:1]};
                n_step = r_step + 1'b1;
                if (r_step == MUL_LAST) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                // dot^2 at or above the norm product clamps to one
                if (r_pd >= r_pn) begin
                    n_sim   = ONE_Q15;
                    n_state = ST_DONE;
                end else begin
                    n_rem   = r_pd;
                    n_q     = '0;
                    n_step  = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_rem  = w_div_ge ? w_diff[PROD_W-1:0] : w_rem2[PROD_W-1:0];
                n_q    = {r_q[QUOT_W-2:0], w_div_ge};
                n_step = r_step + 1'b1;
                if (r_step == DIV_LAST) begin
                    n_srem  = '0;
                    n_root  = '0;
                    n_step  = '0;
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                n_srem = w_sq_ge ? w_sq_diff[SREM_W-1:0] : w_rem4[SREM_W-1:0];
                n_root = {r_root[ROOT_W-2:0], w_sq_ge};
                n_q    = {r_q[QUOT_W-3:0], 2'b00};
                n_step = r_step + 1'b1;
                if (r_step == SQRT_LAST) begin
                    n_sim   = SIM_W'(n_root);
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_sim   = r_sim;
                    n_out_degen = r_degen;
                    n_out_lerr  = r_lerr;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step      <= n_step;
        r_md        <= n_md;
        r_qd        <= n_qd;
        r_pd        <= n_pd;
        r_mn        <= n_mn;
        r_qn        <= n_qn;
        r_pn        <= n_pn;
        r_rem       <= n_rem;
        r_q         <= n_q;
        r_srem      <= n_srem;
        r_root      <= n_root;
        r_sim       <= n_sim;
        r_degen     <= n_degen;
        r_lerr      <= n_lerr;
        r_out_sim   <= n_out_sim;
        r_out_degen <= n_out_degen;
        r_out_lerr  <= n_out_lerr;
    end

    assign o_valid        = r_out_valid;
    assign o_similarity   = r_out_sim;
    assign o_degenerate   = r_out_degen;
    assign o_length_error = r_out_lerr;

endmodule

// ===== dv/tb.sv =====
// testbench for the clamped cosine similarity core: streams vectors, predicts and checks results
module tb;

    import csc_pkg::*;

    localparam int MAX_DIM     = DEF_MAX_DIM;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 200;

    typedef struct {
        logic [SIM_W-1:0] sim;
        logic             degen;
        logic             len_err;
    } t_sim_result;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_stall;
    logic signed [ELEM_BITS-1:0] i_a_elem = '0;
    logic signed [ELEM_BITS-1:0] i_b_elem = '0;
    logic                        i_last = 1'b0;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic [SIM_W-1:0]            o_similarity;
    logic                        o_degenerate;
    logic                        o_length_error;

    t_sim_result       sim_expect_q[$];
    t_sim_result       sim_want;
    logic [DOT_W-1:0]  acc_dot = '0;
    logic [NORM_W-1:0] acc_norm_a = '0;
    logic [NORM_W-1:0] acc_norm_b = '0;
    int                acc_pairs = 0;
    logic              acc_too_long = 1'b0;
    int                mismatch_count = 0;
    int                cycle_count = 0;
    int                tx_max = 0;
    int                rx_max = 0;
    int                rx_wait = 0;

    cosine_similarity_clamped_core #(
        .MAX_DIM(MAX_DIM)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_a_elem       (i_a_elem),
        .i_b_elem       (i_b_elem),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_similarity   (o_similarity),
        .o_degenerate   (o_degenerate),
        .o_length_error (o_length_error)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // largest Q15 s in [0, 32768], i.e. up to 1.0, with s^2 * na * nb <= 2^30 * dot^2
    function automatic logic [SIM_W-1:0] clamped_cosine(input logic [NORM_W-1:0] dot_mag,
                                                        input logic [NORM_W-1:0] na,
                                                        input logic [NORM_W-1:0] nb);
        logic [127:0] norm_prod;
        logic [127:0] dot_sq;
        logic [127:0] lhs;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        norm_prod = 128'(na) * 128'(nb);
        dot_sq    = (128'(dot_mag) * 128'(dot_mag)) << 30;
        lo = 0;
        hi = 32768;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            lhs = norm_prod * 128'(mid * mid);
            if (lhs <= dot_sq) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return SIM_W'(lo);
    endfunction

    task automatic accumulate_pair(input logic signed [ELEM_BITS-1:0] a,
                                   input logic signed [ELEM_BITS-1:0] b, input logic last);
        logic signed [DOT_W-1:0] ab;
        logic signed [DOT_W-1:0] aa;
        logic signed [DOT_W-1:0] bb;
        t_sim_result             res;
        ab = DOT_W'(a) * DOT_W'(b);
        aa = DOT_W'(a) * DOT_W'(a);
        bb = DOT_W'(b) * DOT_W'(b);
        if (acc_pairs >= MAX_DIM) begin
            acc_too_long = 1'b1;
        end else begin
            acc_dot    = acc_dot + ab;
            acc_norm_a = acc_norm_a + aa[NORM_W-1:0];
            acc_norm_b = acc_norm_b + bb[NORM_W-1:0];
            acc_pairs++;
        end
        if (last) begin
            res.sim     = '0;
            res.degen   = 1'b0;
            res.len_err = acc_too_long;
            if (acc_norm_a == '0 || acc_norm_b == '0) begin
                res.degen = 1'b1;
            end else if (!acc_dot[DOT_W-1] && acc_dot != '0) begin
                res.sim = clamped_cosine(acc_dot[DOT_W-2:0], acc_norm_a, acc_norm_b);
            end
            sim_expect_q.push_back(res);
            acc_dot      = '0;
            acc_norm_a   = '0;
            acc_norm_b   = '0;
            acc_pairs    = 0;
            acc_too_long = 1'b0;
        end
    endtask

    task automatic send_pair(input logic signed [ELEM_BITS-1:0] a,
                             input logic signed [ELEM_BITS-1:0] b, input logic last);
        int gap;
        gap = (tx_max == 0) ? 0 : $urandom_range(tx_max, 0);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_a_elem <= a;
        i_b_elem <= b;
        i_last   <= last;
        do @(posedge i_clk); while (o_stall);
        accumulate_pair(a, b, last);
    endtask

    task automatic wait_results();
        i_valid <= 1'b0;
        while (sim_expect_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [ELEM_BITS-1:0] extreme_elem();
        case ($urandom_range(4, 0))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return -16'sd1;
            3: return 16'sd1;
            default: return '0;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (sim_expect_q.size() == 0) begin
                    report_mismatch("result with no request pending", 32'(o_similarity), 0);
                end else begin
                    sim_want = sim_expect_q.pop_front();
                    if (o_similarity !== sim_want.sim)
                        report_mismatch("similarity", 32'(o_similarity), 32'(sim_want.sim));
                    if (o_degenerate !== sim_want.degen)
                        report_mismatch("degenerate", 32'(o_degenerate),
                                        32'(sim_want.degen));
                    if (o_length_error !== sim_want.len_err)
                        report_mismatch("length_error", 32'(o_length_error),
                                        32'(sim_want.len_err));
                end
                rx_wait = (rx_max == 0) ? 0 : $urandom_range(rx_max, 0);
            end else if (rx_wait != 0) begin
                rx_wait--;
            end
        end
        i_stall <= (rx_wait != 0);
    end

    task automatic test_directed();
        tx_max = 13;
        rx_max = 13;
        send_pair(16'sh7fff, 16'sh7fff, 1'b1);
        send_pair(16'sh8000, 16'sh8000, 1'b1);
        send_pair(16'sh8000, 16'sh7fff, 1'b1);
        // zero norm on either side
        send_pair(16'sd0, 16'sd0, 1'b1);
        send_pair(16'sd0, 16'sd123, 1'b1);
        send_pair(-16'sd77, 16'sd0, 1'b1);
        // orthogonal
        send_pair(16'sd1, 16'sd0, 1'b0);
        send_pair(16'sd0, 16'sd1, 1'b1);
        // negative dot product
        send_pair(16'sh7fff, 16'sh8000, 1'b0);
        send_pair(16'sh8000, 16'sh7fff, 1'b1);
        send_pair(16'sd3, 16'sd4, 1'b0);
        send_pair(16'sd4, 16'sd3, 1'b1);
        send_pair(16'sd1, -16'sd1, 1'b0);
        send_pair(-16'sd1, 16'sd1, 1'b0);
        send_pair(16'sd2, 16'sd2, 1'b1);
        send_pair(-16'sd1, -16'sd1, 1'b1);
        send_pair(16'sd1, 16'sh7fff, 1'b1);
        wait_results();
    endtask

    task automatic test_length_error();
        int n;
        tx_max = 0;
        rx_max = 0;
        for (int i = 0; i < MAX_DIM; i++)
            send_pair(16'sh8000, 16'sh8000, i == MAX_DIM - 1);
        tx_max = 3;
        rx_max = 13;
        n = MAX_DIM + 4;
        for (int i = 0; i < n; i++)
            send_pair(16'sh7fff, (i < MAX_DIM) ? 16'sh7fff : 16'sh8000, i == n - 1);
        // accumulators must be clear again
        send_pair(16'sd5, 16'sd5, 1'b1);
        wait_results();
    endtask

    task automatic test_drain_pause();
        tx_max = 13;
        rx_max = 13;
        for (int v = 0; v < 4; v++) begin
            send_pair(16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)), 1'b0);
            send_pair(16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)), 1'b1);
            wait_results();
        end
    endtask

    task automatic test_random();
        int                          items;
        int                          vecs;
        int                          len;
        int                          mode;
        int                          pick;
        logic signed [ELEM_BITS-1:0] a;
        logic signed [ELEM_BITS-1:0] b;
        items = 0;
        vecs  = 0;
        while (items < 90 || vecs < 16) begin
            pick = $urandom_range(99, 0);
            if (pick < 85) begin
                len = $urandom_range(8, 1);
            end else begin
                len = $urandom_range(24, 9);
            end
            mode = $urandom_range(5, 0);
            case ($urandom_range(3, 0))
                0: begin
                    tx_max = 0;
                    rx_max = 0;
                end
                1: begin
                    tx_max = 13;
                    rx_max = 13;
                end
                2: begin
                    tx_max = 13;
                    rx_max = 0;
                end
                default: begin
                    tx_max = 0;
                    rx_max = 13;
                end
            endcase
            for (int i = 0; i < len; i++) begin
                a = 16'($urandom_range(65535, 0));
                b = 16'($urandom_range(65535, 0));
                case (mode)
                    1: begin
                        a = a >>> 1;
                        b = a + (b >>> 10);
                    end
                    2: b = -a;
                    3: begin
                        if ($urandom_range(3, 0) != 0) a = '0;
                        if ($urandom_range(3, 0) == 0) b = '0;
                    end
                    4: begin
                        a = a >>> 13;
                        b = b >>> 13;
                    end
                    5: begin
                        a = extreme_elem();
                        b = extreme_elem();
                    end
                    default: ;
                endcase
                send_pair(a, b, i == len - 1);
                items++;
            end
            vecs++;
        end
        wait_results();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_length_error();
        test_drain_pause();
        test_random();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
